// ----- src/lbcd_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU block cache directory package
// Shared sizes, entry layout, mode codes and the control structs that pass
// between the top level and the scan engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lbcd_pkg;

    // Directory depth and stored index width.
    localparam int MAX_ENTRIES = 64;
    localparam int INDEX_BITS  = 32;

    // Entry address, recency rank and occupancy widths.
    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RANK_W = ADDR_W;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

    // Width of the capacity register and of the occupancy port.
    localparam int CAP_W = 7;

    // Item modes. The unused code behaves as a probe.
    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_FILL   = 2'd1,
        MODE_PROBE  = 2'd2
    } t_mode;

    // One word of the directory memory.
    typedef struct packed {
        logic [INDEX_BITS-1:0] tag;
        logic [RANK_W-1:0]     rank;
    } t_entry;

    // Request handed to the scan engine when an item is accepted.
    typedef struct packed {
        logic [1:0]            mode;
        logic [INDEX_BITS-1:0] tag;
        logic [CNT_W-1:0]      cap;
    } t_req;

    // Result returned by the scan engine.
    typedef struct packed {
        logic                  hit;
        logic                  ev_valid;
        logic [INDEX_BITS-1:0] ev_tag;
        logic [CNT_W-1:0]      count;
    } t_rsp;

    // Scan engine sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ----- src/lru_block_cache_directory.sv -----
// ----------------------------------------------------------------------------
// LRU block cache directory
// Fully associative directory of block indices with least recently used
// replacement, built around one synchronous tag and rank memory.
// ----------------------------------------------------------------------------
// Each item runs a search pass; a lookup hit or a fill then runs an update
// pass, and each pass does one memory read per entry. A new item is taken
// only once the engine has handed on the result of the last one.
// Reset: synchronous and active low; the directory comes up empty with the
// capacity register at 64. No clearing pass is needed.
`default_nettype none

module lru_block_cache_directory (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel: capacity register.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [6:0]  i_cfg_capacity_blocks,
    // Input item channel.
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_block_index,
    // Result channel.
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_hit,
    output logic             o_evicted_valid,
    output logic [31:0]      o_evicted_index,
    output logic [6:0]       o_occupancy
);

    // The capacity register is always writable. The user must change the
    // configuration only while the block is idle; no handshake enforces it.
    logic [lbcd_pkg::CAP_W-1:0] r_cap;

    // Result register. It lets the engine start the next item while a
    // finished result still waits for the consumer.
    logic                            r_out_valid;
    logic                            r_hit;
    logic                            r_ev_valid;
    logic [lbcd_pkg::INDEX_BITS-1:0] r_ev_tag;
    logic [lbcd_pkg::CNT_W-1:0]      r_occ;

    logic                       eng_idle;
    logic                       eng_done;
    logic                       start;
    logic                       release_rsp;
    logic [lbcd_pkg::CNT_W-1:0] eff_cap;
    lbcd_pkg::t_req             req;
    lbcd_pkg::t_rsp             rsp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lbcd_pkg::CAP_W'(64);
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_capacity_blocks;
        end
    end

    // A capacity of zero acts as one, and anything above the directory
    // depth is clamped to the depth.
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = lbcd_pkg::CNT_W'(1);
        end else if (int'(r_cap) > lbcd_pkg::MAX_ENTRIES) begin
            eff_cap = lbcd_pkg::CNT_W'(lbcd_pkg::MAX_ENTRIES);
        end else begin
            eff_cap = lbcd_pkg::CNT_W'(r_cap);
        end
    end

    // The engine works on one item at a time, so an input beat is taken
    // whenever the engine is idle.
    assign o_in_ready = eng_idle;
    assign start      = i_in_valid && eng_idle;

    // The stored tag is the block index cut or zero-extended to the tag width.
    assign req.mode = i_mode;
    assign req.tag  = lbcd_pkg::INDEX_BITS'(i_block_index);
    assign req.cap  = eff_cap;

    // A finished result moves into the result register as soon as that
    // register is empty or being drained in the same cycle.
    assign release_rsp = eng_done && (!r_out_valid || i_out_ready);

    lbcd_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_req     (req),
        .i_release (release_rsp),
        .o_idle    (eng_idle),
        .o_done    (eng_done),
        .o_rsp     (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (release_rsp) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (release_rsp) begin
            r_hit      <= rsp.hit;
            r_ev_valid <= rsp.ev_valid;
            r_ev_tag   <= rsp.ev_tag;
            r_occ      <= rsp.count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_hit;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_index = 32'(r_ev_tag);
    assign o_occupancy     = 7'(r_occ);

endmodule

`default_nettype wire

// ----- src/lbcd_engine.sv -----
// ----------------------------------------------------------------------------
// LRU block cache directory scan engine
// Holds the tag and rank memory, the valid bits and the occupancy, and runs
// the search pass and the read-modify-write update pass for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module lbcd_engine (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire lbcd_pkg::t_req i_req,
    input  wire logic          i_release,
    output logic               o_idle,
    output logic               o_done,
    output lbcd_pkg::t_rsp     o_rsp
);

    localparam logic [lbcd_pkg::ADDR_W-1:0] LAST_ADDR =
        lbcd_pkg::ADDR_W'(lbcd_pkg::MAX_ENTRIES - 1);

    lbcd_pkg::t_entry r_mem [lbcd_pkg::MAX_ENTRIES];
    lbcd_pkg::t_entry r_rd_data;

    lbcd_pkg::t_state r_state;
    lbcd_pkg::t_req   r_req;
    lbcd_pkg::t_rsp   r_rsp;

    logic [lbcd_pkg::MAX_ENTRIES-1:0] r_valid;
    logic [lbcd_pkg::CNT_W-1:0]       r_count;
    logic [lbcd_pkg::ADDR_W-1:0]      r_ptr;
    logic [lbcd_pkg::ADDR_W-1:0]      r_daddr;
    logic                             r_issue;
    logic                             r_pend;
    logic                             r_found;
    logic [lbcd_pkg::ADDR_W-1:0]      r_fidx;
    logic [lbcd_pkg::RANK_W-1:0]      r_frank;
    logic [lbcd_pkg::INDEX_BITS-1:0]  r_old_tag;
    logic                             r_full;
    logic                             r_ins;

    logic                       rd_en;
    logic                       last_beat;
    logic                       cur_v;
    logic                       match;
    logic                       oldest;
    logic                       found_now;
    logic                       evict;
    logic                       wr_en;
    lbcd_pkg::t_entry           wr_data;
    logic                       vset;
    logic                       vclr;
    logic [lbcd_pkg::CNT_W-1:0] cur_rank;
    logic [lbcd_pkg::CNT_W-1:0] n_count;

    assign rd_en     = ((r_state == lbcd_pkg::ST_SEARCH) || (r_state == lbcd_pkg::ST_UPDATE))
                       && r_issue;
    assign last_beat = r_pend && (r_daddr == LAST_ADDR);
    assign cur_v     = r_valid[r_daddr];
    assign cur_rank  = lbcd_pkg::CNT_W'(r_rd_data.rank);
    assign match     = cur_v && (r_rd_data.tag == r_req.tag);
    assign oldest    = cur_v && ((cur_rank + 1'b1) == r_count);
    assign found_now = r_found || match;
    assign evict     = cur_v && r_full && (cur_rank >= (r_req.cap - 1'b1));

    // Update pass: a touch ages every younger entry, a fill ages everything
    // that stays and drops the new tag into the first free or evicted slot.
    always_comb begin
        wr_en   = 1'b0;
        wr_data = r_rd_data;
        vset    = 1'b0;
        vclr    = 1'b0;
        if ((r_state == lbcd_pkg::ST_UPDATE) && r_pend) begin
            if (r_found) begin
                wr_en = cur_v;
                if (r_daddr == r_fidx) begin
                    wr_data.rank = '0;
                end else if (r_rd_data.rank < r_frank) begin
                    wr_data.rank = r_rd_data.rank + 1'b1;
                end
            end else if ((!cur_v || evict) && !r_ins) begin
                wr_en        = 1'b1;
                wr_data.tag  = r_req.tag;
                wr_data.rank = '0;
                vset         = 1'b1;
            end else if (evict) begin
                vclr = 1'b1;
            end else if (cur_v) begin
                wr_en        = 1'b1;
                wr_data.rank = r_rd_data.rank + 1'b1;
            end
        end
    end

    always_comb begin
        if (r_found) begin
            n_count = r_count;
        end else if (r_full) begin
            n_count = r_req.cap;
        end else begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_ptr];
        end
        if (wr_en) begin
            r_mem[r_daddr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbcd_pkg::ST_IDLE;
            r_valid <= '0;
            r_count <= '0;
            r_issue <= 1'b0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_full  <= 1'b0;
            r_ins   <= 1'b0;
            r_ptr   <= '0;
        end else begin
            r_pend <= rd_en;
            if (rd_en) begin
                r_daddr <= r_ptr;
                r_ptr   <= r_ptr + 1'b1;
                if (r_ptr == LAST_ADDR) begin
                    r_issue <= 1'b0;
                end
            end
            if (vset) begin
                r_valid[r_daddr] <= 1'b1;
                r_ins            <= 1'b1;
            end
            if (vclr) begin
                r_valid[r_daddr] <= 1'b0;
            end
            case (r_state)
                lbcd_pkg::ST_IDLE: begin
                    if (i_start) begin
                        r_req   <= i_req;
                        r_ptr   <= '0;
                        r_issue <= 1'b1;
                        r_found <= 1'b0;
                        r_full  <= (r_count >= i_req.cap);
                        r_state <= lbcd_pkg::ST_SEARCH;
                    end
                end
                lbcd_pkg::ST_SEARCH: begin
                    if (r_pend) begin
                        if (match && !r_found) begin
                            r_found <= 1'b1;
                            r_fidx  <= r_daddr;
                            r_frank <= r_rd_data.rank;
                        end
                        if (oldest) begin
                            r_old_tag <= r_rd_data.tag;
                        end
                    end
                    if (last_beat) begin
                        if ((r_req.mode == lbcd_pkg::MODE_FILL) ||
                            ((r_req.mode == lbcd_pkg::MODE_LOOKUP) && found_now)) begin
                            r_ptr   <= '0;
                            r_issue <= 1'b1;
                            r_ins   <= 1'b0;
                            r_state <= lbcd_pkg::ST_UPDATE;
                        end else begin
                            r_rsp.hit      <= found_now;
                            r_rsp.ev_valid <= 1'b0;
                            r_rsp.ev_tag   <= '0;
                            r_rsp.count    <= r_count;
                            r_state        <= lbcd_pkg::ST_FINISH;
                        end
                    end
                end
                lbcd_pkg::ST_UPDATE: begin
                    if (last_beat) begin
                        r_rsp.hit      <= r_found;
                        r_rsp.ev_valid <= !r_found && r_full;
                        r_rsp.ev_tag   <= (!r_found && r_full) ? r_old_tag : '0;
                        r_rsp.count    <= n_count;
                        r_count        <= n_count;
                        r_state        <= lbcd_pkg::ST_FINISH;
                    end
                end
                lbcd_pkg::ST_FINISH: begin
                    if (i_release) begin
                        r_state <= lbcd_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= lbcd_pkg::ST_IDLE;
                end
            endcase
        end
    end

    assign o_idle = (r_state == lbcd_pkg::ST_IDLE);
    assign o_done = (r_state == lbcd_pkg::ST_FINISH);
    assign o_rsp  = r_rsp;

endmodule

`default_nettype wire

// ----- src/lbcd_checker.sv -----
// ----------------------------------------------------------------------------
// LRU block cache directory port checker
// Watches the top level ports for result consistency and item sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module lbcd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_hit,
    input wire logic        o_evicted_valid,
    input wire logic [31:0] o_evicted_index,
    input wire logic [6:0]  o_occupancy
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped before it was taken");

    // No eviction means the evicted index reads zero.
    a_ev_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_evicted_valid |-> o_evicted_index == 32'd0)
        else $error("evicted index nonzero without eviction");

    // Only a fill of a new block evicts, and the directory is not empty after.
    a_ev_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_evicted_valid |-> !o_hit && o_occupancy != 7'd0)
        else $error("eviction reported on a hit or with an empty directory");

    // One item at a time: the input side closes right after a beat.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while the first is in flight");

endmodule

bind lru_block_cache_directory lbcd_checker u_lbcd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_hit           (o_hit),
    .o_evicted_valid (o_evicted_valid),
    .o_evicted_index (o_evicted_index),
    .o_occupancy     (o_occupancy)
);

`default_nettype wire

// ----- tb/lru_block_cache_directory_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU block cache directory testbench
// Drives lookup, fill and probe beats into the directory and checks every
// result beat against a typed table entry or a shadow directory. A short
// table of directed beats comes first, then random phases at many capacity
// settings with random idling on both channels.
// ----------------------------------------------------------------------------

module lru_block_cache_directory_tb;

    // The mode code that the package leaves unnamed. It must act as a probe.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Pacing of the random part.
    localparam int IDLE_PCT      = 13;    // chance of an idle cycle per side
    localparam int PHASE_COUNT   = 10;
    localparam int PHASE_ITEMS   = 100;
    localparam int HOLD_CYCLES   = 600;   // long result back-pressure stretch
    localparam int DRAIN_CYCLES  = 150;   // tail after the last result beat
    // The limit leaves several times the margin of a slow item plus the long
    // hold.
    localparam int STALL_LIMIT   = 4000;

    // Storage for the directed table, the owed results and the index pool.
    localparam int TABLE_DEPTH   = 32;
    localparam int OWED_DEPTH    = 16;
    localparam int POOL_DEPTH    = lbcd_pkg::MAX_ENTRIES + 8;

    // One result beat as the directory reports it.
    typedef struct packed {
        logic        hit;
        logic        evicted_valid;
        logic [31:0] evicted_index;
        logic [6:0]  occupancy;
    } t_dir_result;

    localparam t_dir_result NO_CHECK = '0;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    // One row of the directed table. Rows with typed set carry their own
    // expected result; the others are checked against the shadow directory.
    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  mode;
        logic [31:0] value;
        logic        typed;
        t_dir_result want;
    } t_stim_row;

    // ------------------------------------------------------------------------
    // Block ports.
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_capacity_blocks;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_mode;
    logic [31:0] i_block_index;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_hit;
    logic        o_evicted_valid;
    logic [31:0] o_evicted_index;
    logic [6:0]  o_occupancy;

    lru_block_cache_directory dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_capacity_blocks (i_cfg_capacity_blocks),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_mode                (i_mode),
        .i_block_index         (i_block_index),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_hit                 (o_hit),
        .o_evicted_valid       (o_evicted_valid),
        .o_evicted_index       (o_evicted_index),
        .o_occupancy           (o_occupancy)
    );

    // ------------------------------------------------------------------------
    // Clock: 10 ns period.
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow directory. It comes up empty with the capacity at 64, just as
    // the block does after reset, and is only ever updated on accepted beats.
    // ------------------------------------------------------------------------
    logic [31:0] shadow_tag   [lbcd_pkg::MAX_ENTRIES];
    bit          shadow_valid [lbcd_pkg::MAX_ENTRIES];
    int          shadow_rank  [lbcd_pkg::MAX_ENTRIES];
    int          shadow_count    = 0;
    logic [6:0]  shadow_capacity = 7'd64;

    // Results still owed by the block, oldest first, in a ring.
    t_dir_result owed_results [OWED_DEPTH];
    int          owed_wr = 0;
    int          owed_rd = 0;

    // Directed stimulus table.
    t_stim_row   stim_table [TABLE_DEPTH];
    int          stim_rows = 0;

    // Side information that travels with the beat on the input channel.
    logic        cur_typed;
    t_dir_result cur_want;

    int  failures      = 0;
    bit  no_idle       = 1'b0;
    bit  hold_request  = 1'b0;
    int  quiet_cycles  = 0;

    // Apply one access to the shadow directory and return what the block
    // must report for it.
    function automatic t_dir_result access_directory(logic [1:0] mode,
                                                     logic [31:0] index);
        t_dir_result res;
        logic [31:0] tag;
        int          found;
        int          cap;
        int          age;
        int          k;
        bit          removed;

        // Only the low tag-width bits of the index take part.
        tag   = index & 32'((64'd1 << lbcd_pkg::INDEX_BITS) - 64'd1);
        res   = '0;
        found = -1;
        for (k = 0; k < lbcd_pkg::MAX_ENTRIES; k++) begin
            if (found < 0 && shadow_valid[k] && shadow_tag[k] == tag) begin
                found = k;
            end
        end
        res.hit = (found >= 0);

        if ((mode == lbcd_pkg::MODE_LOOKUP || mode == lbcd_pkg::MODE_FILL) &&
            found >= 0) begin
            // Touch: every entry younger than the hit ages by one.
            age = shadow_rank[found];
            for (k = 0; k < lbcd_pkg::MAX_ENTRIES; k++) begin
                if (shadow_valid[k] && shadow_rank[k] < age) begin
                    shadow_rank[k]++;
                end
            end
            shadow_rank[found] = 0;
        end else if (mode == lbcd_pkg::MODE_FILL) begin
            // Capacity zero acts as one, anything above the depth saturates.
            cap = shadow_capacity;
            if (cap < 1) begin
                cap = 1;
            end
            if (cap > lbcd_pkg::MAX_ENTRIES) begin
                cap = lbcd_pkg::MAX_ENTRIES;
            end
            // Evict oldest entries until the new one fits; only the first
            // victim is reported.
            while (shadow_count >= cap && shadow_count > 0) begin
                removed = 1'b0;
                for (k = 0; k < lbcd_pkg::MAX_ENTRIES; k++) begin
                    if (!removed && shadow_valid[k] &&
                        shadow_rank[k] + 1 == shadow_count) begin
                        removed = 1'b1;
                        if (!res.evicted_valid) begin
                            res.evicted_valid = 1'b1;
                            res.evicted_index = shadow_tag[k];
                        end
                        shadow_valid[k] = 1'b0;
                        shadow_rank[k]  = 0;
                    end
                end
                shadow_count--;
            end
            for (k = 0; k < lbcd_pkg::MAX_ENTRIES; k++) begin
                if (shadow_valid[k]) begin
                    shadow_rank[k]++;
                end
            end
            removed = 1'b0;
            for (k = 0; k < lbcd_pkg::MAX_ENTRIES; k++) begin
                if (!removed && !shadow_valid[k]) begin
                    removed         = 1'b1;
                    shadow_valid[k] = 1'b1;
                    shadow_tag[k]   = tag;
                    shadow_rank[k]  = 0;
                    shadow_count++;
                end
            end
        end

        res.occupancy = shadow_count[6:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge; the inputs were set
    // at the falling edge, so nothing here races with the block.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_dir_result want;
        t_dir_result got;

        if (i_rst_n) begin
            // The result beat is checked first: it always belongs to an
            // older item than an input beat taken at the same edge.
            if (o_out_valid && i_out_ready) begin
                if (owed_wr == owed_rd) begin
                    $error("result beat arrived with no result pending");
                    failures++;
                end else begin
                    want = owed_results[owed_rd % OWED_DEPTH];
                    owed_rd++;
                    if (o_hit !== want.hit) begin
                        $error("hit mismatch: expected %0d, actual %0d",
                               want.hit, o_hit);
                        failures++;
                    end
                    if (o_evicted_valid !== want.evicted_valid) begin
                        $error("evicted_valid mismatch: expected %0d, actual %0d",
                               want.evicted_valid, o_evicted_valid);
                        failures++;
                    end
                    if (o_evicted_index !== want.evicted_index) begin
                        $error("evicted_index mismatch: expected %h, actual %h",
                               want.evicted_index, o_evicted_index);
                        failures++;
                    end
                    if (o_occupancy !== want.occupancy) begin
                        $error("occupancy mismatch: expected %0d, actual %0d",
                               want.occupancy, o_occupancy);
                        failures++;
                    end
                end
            end

            if (i_cfg_valid && o_cfg_ready) begin
                shadow_capacity = i_cfg_capacity_blocks;
            end

            if (i_in_valid && o_in_ready) begin
                got = access_directory(i_mode, i_block_index);
                if (owed_wr - owed_rd >= OWED_DEPTH) begin
                    $error("more results owed than the ring can hold");
                    failures++;
                end else begin
                    owed_results[owed_wr % OWED_DEPTH] = cur_typed ? cur_want : got;
                    owed_wr++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when no beat moves on any channel for too long.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("lru_block_cache_directory test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result sink. It idles at random, except in the no-idle phase, and once
    // holds ready low for a long stretch so that the block backs up and
    // stops taking input beats.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int k;

        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++) begin
                    @(negedge i_clk);
                end
            end else begin
                i_out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input channel driver. The beat is held until it is taken; valid stays
    // high into the next falling edge, where the next call either lowers it
    // for an idle cycle or puts up the next beat.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] mode, input logic [31:0] index,
                             input logic typed, input t_dir_result want);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_block_index <= index;
        cur_typed     <= typed;
        cur_want      <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // The capacity is only written with the block idle: the input channel is
    // parked and every owed result must have come back first. This is also
    // where the sender pauses until nothing is outstanding.
    task automatic write_capacity(input logic [6:0] value);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (owed_wr != owed_rd) begin
            @(negedge i_clk);
        end
        i_cfg_valid           <= 1'b1;
        i_cfg_capacity_blocks <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_stim_row item_row(logic [1:0] mode, logic [31:0] index,
                                           logic typed, t_dir_result want);
        t_stim_row row;

        row.kind  = ROW_ITEM;
        row.mode  = mode;
        row.value = index;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic t_stim_row cfg_row(logic [6:0] capacity);
        t_stim_row row;

        row       = '0;
        row.kind  = ROW_CFG;
        row.value = {25'd0, capacity};
        return row;
    endfunction

    // Append one row to the directed table.
    function automatic void add_row(t_stim_row row);
        if (stim_rows >= TABLE_DEPTH) begin
            $error("directed table is full");
            failures++;
        end else begin
            stim_table[stim_rows] = row;
            stim_rows++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] pool [POOL_DEPTH];
        int          pool_size;
        int          pool_span;
        int          phase_caps [PHASE_COUNT];
        int          r;
        int          ph;
        int          n;
        int          cap_eff;
        int          pick;
        logic [1:0]  mode;
        logic [31:0] index;

        i_rst_n               = 1'b0;
        i_cfg_valid           = 1'b0;
        i_cfg_capacity_blocks = 7'd0;
        i_in_valid            = 1'b0;
        i_mode                = lbcd_pkg::MODE_LOOKUP;
        i_block_index         = 32'd0;
        cur_typed             = 1'b0;
        cur_want              = NO_CHECK;

        // After reset the directory is empty with room for 64 blocks, so the
        // first rows can be read off directly: misses on an empty store, two
        // fills, then a refresh, a lookup hit, a probe hit and the spare mode
        // acting as a probe.
        add_row(item_row(lbcd_pkg::MODE_PROBE,  32'h0000_0000, 1'b1,
                         '{1'b0, 1'b0, 32'h0, 7'd0}));
        add_row(item_row(lbcd_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 1'b1,
                         '{1'b0, 1'b0, 32'h0, 7'd0}));
        add_row(item_row(MODE_SPARE,            32'h1234_5678, 1'b1,
                         '{1'b0, 1'b0, 32'h0, 7'd0}));
        add_row(item_row(lbcd_pkg::MODE_FILL,   32'h0000_0000, 1'b1,
                         '{1'b0, 1'b0, 32'h0, 7'd1}));
        add_row(item_row(lbcd_pkg::MODE_FILL,   32'hFFFF_FFFF, 1'b1,
                         '{1'b0, 1'b0, 32'h0, 7'd2}));
        add_row(item_row(lbcd_pkg::MODE_FILL,   32'h0000_0000, 1'b1,
                         '{1'b1, 1'b0, 32'h0, 7'd2}));
        add_row(item_row(lbcd_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 1'b1,
                         '{1'b1, 1'b0, 32'h0, 7'd2}));
        add_row(item_row(lbcd_pkg::MODE_PROBE,  32'h0000_0000, 1'b1,
                         '{1'b1, 1'b0, 32'h0, 7'd2}));
        add_row(item_row(MODE_SPARE,            32'hFFFF_FFFF, 1'b1,
                         '{1'b1, 1'b0, 32'h0, 7'd2}));
        // Capacity lowered below occupancy: probe and refresh leave the
        // store alone, then a new fill evicts twice and reports the oldest.
        add_row(cfg_row(7'd1));
        add_row(item_row(lbcd_pkg::MODE_PROBE,  32'h0000_0000, 1'b0, NO_CHECK));
        add_row(item_row(lbcd_pkg::MODE_FILL,   32'h0000_0000, 1'b0, NO_CHECK));
        add_row(item_row(lbcd_pkg::MODE_FILL,   32'hA5A5_A5A5, 1'b0, NO_CHECK));
        // Capacity zero behaves as one.
        add_row(cfg_row(7'd0));
        add_row(item_row(lbcd_pkg::MODE_FILL,   32'h5A5A_5A5A, 1'b0, NO_CHECK));
        add_row(item_row(lbcd_pkg::MODE_LOOKUP, 32'h5A5A_5A5A, 1'b0, NO_CHECK));
        // Capacity above the depth saturates.
        add_row(cfg_row(7'd127));
        add_row(item_row(lbcd_pkg::MODE_FILL,   32'h8000_0000, 1'b0, NO_CHECK));
        add_row(item_row(lbcd_pkg::MODE_FILL,   32'h0000_0001, 1'b0, NO_CHECK));
        add_row(cfg_row(7'd2));
        add_row(item_row(lbcd_pkg::MODE_FILL,   32'h0000_0003, 1'b0, NO_CHECK));
        add_row(item_row(lbcd_pkg::MODE_LOOKUP, 32'h8000_0000, 1'b0, NO_CHECK));
        add_row(item_row(lbcd_pkg::MODE_PROBE,  32'h0000_0001, 1'b0, NO_CHECK));
        add_row(cfg_row(7'd64));

        // Capacity of each random phase: both extremes, the saturating and
        // zero codes, and a drop to a tiny capacity right after the store
        // has had the chance to fill completely.
        phase_caps = '{64, 127, 3, 1, 0, 64, 2, 65, 8, 63};

        // Reset is held low from the start and released at a falling edge.
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < stim_rows; r++) begin
            if (stim_table[r].kind == ROW_CFG) begin
                write_capacity(stim_table[r].value[6:0]);
            end else begin
                send_item(stim_table[r].mode, stim_table[r].value,
                          stim_table[r].typed, stim_table[r].want);
            end
        end

        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            write_capacity(phase_caps[ph][6:0]);
            // Phase five runs with no idling at all; phase one starts with
            // the long result hold while input beats keep coming.
            no_idle = (ph == 5);
            if (ph == 1) begin
                hold_request = 1'b1;
            end

            // Draw a pool a little larger than the capacity so that hits,
            // refreshes and evictions all happen often.
            cap_eff = phase_caps[ph];
            if (cap_eff < 1) begin
                cap_eff = 1;
            end
            if (cap_eff > lbcd_pkg::MAX_ENTRIES) begin
                cap_eff = lbcd_pkg::MAX_ENTRIES;
            end
            pool_span = cap_eff + $urandom_range(6, 1);
            pool_size = 0;
            for (n = 0; n < pool_span; n++) begin
                pool[pool_size] = $urandom;
                pool_size++;
            end

            for (n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 50) begin
                    mode = lbcd_pkg::MODE_FILL;
                end else if (pick < 75) begin
                    mode = lbcd_pkg::MODE_LOOKUP;
                end else if (pick < 92) begin
                    mode = lbcd_pkg::MODE_PROBE;
                end else begin
                    mode = MODE_SPARE;
                end
                // Mostly pool indices; now and then a wild one as noise.
                if ($urandom_range(9) == 0) begin
                    index = $urandom;
                end else begin
                    index = pool[$urandom_range(pool_size - 1)];
                end
                send_item(mode, index, 1'b0, NO_CHECK);
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        no_idle = 1'b0;

        // Wait for the owed results; the watchdog bounds this wait.
        while (owed_wr != owed_rd) begin
            @(posedge i_clk);
        end
        // Let a full slow item's worth of cycles pass to catch stray beats.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (failures == 0) begin
            $display("lru_block_cache_directory test passed");
        end else begin
            $display("lru_block_cache_directory test failed");
        end
        $finish;
    end

endmodule

// ----- lru_block_cache_directory.f -----
src/lbcd_pkg.sv
src/lbcd_engine.sv
src/lru_block_cache_directory.sv
src/lbcd_checker.sv
tb/lru_block_cache_directory_tb.sv
